FILE: design/uer_pkg.sv
// Shared types, codes and constants for the ultrasonic echo ranger.
`default_nettype none

package uer_pkg;

    // Default width of the phase counter
    localparam int COUNT_WIDTH_DEF = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_MIN_PULSE = 2'd1;
    localparam logic [1:0] CFG_TRIGGER   = 2'd2;

    // Configuration reset values
    localparam logic [15:0] TIMEOUT_RST   = 16'd30000;
    localparam logic [15:0] MIN_PULSE_RST = 16'd100;
    localparam logic [7:0]  TRIGGER_RST   = 8'd10;

    // Measurement phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_WAIT_LOW  = 3'd1;
    localparam logic [2:0] PH_TRIGGER   = 3'd2;
    localparam logic [2:0] PH_WAIT_RISE = 3'd3;
    localparam logic [2:0] PH_MEASURE   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;

    // Distance scale: 1756/1024 hundredths of a cm per tick (0.0343/2 cm per us)
    localparam int          DIST_SHIFT = 10;
    localparam logic [10:0] DIST_MULT  = 11'd1756;
    localparam int          PROD_W     = 16 + 11;

    typedef struct packed {
        logic echo_level;
        logic start_req;
    } t_in;

    typedef struct packed {
        logic        trigger_level;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] pulse_width;
        logic [16:0] distance;
    } t_out;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [15:0] min_pulse_ticks;
        logic [7:0]  trigger_ticks;
    } t_cfg;

    // Sequencer result handed to the scaling stage
    typedef struct packed {
        logic        trigger_level;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] pulse_width;
        logic        dist_en;
    } t_mid;

endpackage

`default_nettype wire

FILE: design/ultrasonic_echo_ranger_unit.sv
// Ultrasonic echo ranger: top level.
// Two register stages: an accepted item passes the sequencer result register, then the output register.
// Throughput: one item per cycle while the output side takes items.
// The distance multiply (16x11) sits alone in the second register stage.
// Reset (synchronous, active low) returns to idle with count zero, empties both
// stages and loads the configuration defaults 30000, 100 and 10.
`default_nettype none

module ultrasonic_echo_ranger_unit #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_wdata,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire uer_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output uer_pkg::t_out      o_out_data
);
    import uer_pkg::*;

    t_cfg cfg;
    t_mid mid;
    logic mid_valid;
    logic mid_ready;

    uer_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    uer_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_nxt_ready (mid_ready),
        .o_mid_valid (mid_valid),
        .o_mid       (mid)
    );

    uer_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .o_mid_ready (mid_ready),
        .i_mid       (mid),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: design/uer_cfg_regs.sv
// Configuration register file of the echo ranger.
`default_nettype none

module uer_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_wdata,
    output uer_pkg::t_cfg      o_cfg
);
    import uer_pkg::*;

    t_cfg r_cfg;

    // Indexed writes; unused index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks   <= TIMEOUT_RST;
            r_cfg.min_pulse_ticks <= MIN_PULSE_RST;
            r_cfg.trigger_ticks   <= TRIGGER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMEOUT:   r_cfg.timeout_ticks   <= i_cfg_wdata;
                CFG_MIN_PULSE: r_cfg.min_pulse_ticks <= i_cfg_wdata;
                CFG_TRIGGER:   r_cfg.trigger_ticks   <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: design/uer_seq.sv
// Measurement sequencer: phase and count state, one tick per accepted item.
`default_nettype none

module uer_seq #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire uer_pkg::t_cfg i_cfg,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire uer_pkg::t_in  i_in_data,
    input  wire logic          i_nxt_ready,
    output logic               o_mid_valid,
    output uer_pkg::t_mid      o_mid
);
    import uer_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [2:0]             r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_mid_valid;
    t_mid                   r_mid, n_mid;

    logic                   in_fire;
    logic                   expired;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [CMP_W-1:0]       cnt_ext;
    logic [15:0]            pulse_sat;

    // Stage slot frees when empty or when the next stage takes it
    assign o_in_ready = !r_mid_valid || i_nxt_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    assign cnt_ext   = CMP_W'(r_count);
    assign expired   = (cnt_ext >= CMP_W'(i_cfg.timeout_ticks)) || (r_count == CNT_MAX);
    assign cnt_inc   = (r_count != CNT_MAX) ? r_count + COUNT_WIDTH'(1) : r_count;
    assign pulse_sat = (cnt_ext > CMP_W'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];

    // Next phase, count and result for this tick
    always_comb begin
        n_phase         = r_phase;
        n_count         = r_count;
        n_mid           = '0;
        n_mid.status    = ST_OK;
        case (r_phase)
            PH_WAIT_LOW: begin
                if (!i_in_data.echo_level) begin
                    n_phase = PH_TRIGGER;
                    n_count = '0;
                end else if (expired) begin
                    n_mid.done_res = 1'b1;
                    n_mid.status   = ST_TIMEOUT;
                end else begin
                    n_count = r_count + COUNT_WIDTH'(1);
                end
            end
            PH_TRIGGER: begin
                // echo ignored while the trigger is driven
                if (cnt_inc >= COUNT_WIDTH'(i_cfg.trigger_ticks)) begin
                    n_phase = PH_WAIT_RISE;
                    n_count = '0;
                end else begin
                    n_count = cnt_inc;
                end
            end
            PH_WAIT_RISE: begin
                if (i_in_data.echo_level) begin
                    n_phase = PH_MEASURE;
                    n_count = COUNT_WIDTH'(1);
                end else if (expired) begin
                    n_mid.done_res = 1'b1;
                    n_mid.status   = ST_TIMEOUT;
                end else begin
                    n_count = r_count + COUNT_WIDTH'(1);
                end
            end
            PH_MEASURE: begin
                if (!i_in_data.echo_level) begin
                    n_mid.done_res    = 1'b1;
                    n_mid.pulse_width = pulse_sat;
                    if (pulse_sat < i_cfg.min_pulse_ticks) begin
                        n_mid.status = ST_SHORT;
                    end else begin
                        n_mid.dist_en = 1'b1;
                    end
                end else if (expired) begin
                    n_mid.done_res = 1'b1;
                    n_mid.status   = ST_TIMEOUT;
                end else begin
                    n_count = r_count + COUNT_WIDTH'(1);
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_in_data.start_req) begin
                    n_phase = PH_WAIT_LOW;
                    n_count = '0;
                end
            end
        endcase
        if (n_mid.done_res) begin
            n_phase = PH_IDLE;
            n_count = '0;
        end
        n_mid.trigger_level = (n_phase == PH_TRIGGER);
        n_mid.busy_res      = (n_phase != PH_IDLE);
    end

    // State advances only on accepted ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_mid_valid <= 1'b0;
        end else begin
            r_mid_valid <= in_fire || (r_mid_valid && !i_nxt_ready);
            if (in_fire) begin
                r_phase <= n_phase;
                r_count <= n_count;
            end
        end
    end

    // Result register, payload only
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mid <= n_mid;
        end
    end

    assign o_mid_valid = r_mid_valid;
    assign o_mid       = r_mid;

endmodule

`default_nettype wire

FILE: design/uer_scale.sv
// Distance scaling stage and output register.
`default_nettype none

module uer_scale (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_mid_valid,
    output logic               o_mid_ready,
    input  wire uer_pkg::t_mid i_mid,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output uer_pkg::t_out      o_out_data
);
    import uer_pkg::*;

    logic              r_out_valid;
    t_out              r_out, n_out;
    logic              take;
    logic [PROD_W-1:0] prod;

    assign o_mid_ready = !r_out_valid || i_out_ready;
    assign take        = i_mid_valid && o_mid_ready;

    // pulse * 1756 >> 10, zero unless a good pulse
    assign prod = PROD_W'(i_mid.pulse_width) * PROD_W'(DIST_MULT);

    always_comb begin
        n_out.trigger_level = i_mid.trigger_level;
        n_out.busy_res      = i_mid.busy_res;
        n_out.done_res      = i_mid.done_res;
        n_out.status        = i_mid.status;
        n_out.pulse_width   = i_mid.pulse_width;
        n_out.distance      = i_mid.dist_en ? prod[PROD_W-1:DIST_SHIFT] : 17'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= take || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: design/uer_checker.sv
// Port-level checker for the echo ranger and its bind.
`default_nettype none

module uer_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          o_out_valid,
    input  wire logic          i_out_ready,
    input  wire uer_pkg::t_out o_out_data
);
    import uer_pkg::*;

    // A finished measurement leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res && !o_out_data.trigger_level)
        else $error("done item shows busy or trigger");

    // Trigger only during a measurement
    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.trigger_level |-> o_out_data.busy_res)
        else $error("trigger without busy");

    // Status and measurement fields are quiet on non-final ticks
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.done_res |->
            o_out_data.status == ST_OK && o_out_data.pulse_width == 16'd0
            && o_out_data.distance == 17'd0)
        else $error("result fields set without done");

    // Distance only for a good pulse
    a_dist_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.distance != 17'd0 |->
            o_out_data.status == ST_OK && o_out_data.pulse_width != 16'd0)
        else $error("distance on a rejected pulse");

    // Stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output item changed while stalled");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
